@@ sv/bmh_pkg.sv @@
package bmh_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int PRIO_W       = 32;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int OCC_W        = 7;
  localparam int OCC_MAX      = 127;
  // wide enough for any count up to the largest capacity (4096)
  localparam int CMP_W        = 13;

  localparam logic signed [PRIO_W-1:0] INT_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_EXTRACT  = 2'd1,
    MODE_DECREASE = 2'd2,
    MODE_DELETE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [DATA_W-1:0]        data;
  } entry_t;

endpackage

@@ sv/bmh_in_if.sv @@
interface bmh_in_if import bmh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic signed [PRIO_W-1:0] priority_req;
  logic [DATA_W-1:0]        payload;
  logic [POS_W-1:0]         position;

  modport source (output valid, mode, priority_req, payload, position, input ready);
  modport sink   (input valid, mode, priority_req, payload, position, output ready);
endinterface

@@ sv/bmh_out_if.sv @@
interface bmh_out_if import bmh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [PRIO_W-1:0] out_priority;
  logic [DATA_W-1:0]        out_payload;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, status, out_priority, out_payload, occupancy, input ready);
  modport sink   (input valid, status, out_priority, out_payload, occupancy, output ready);
endinterface

@@ sv/bmh_ram.sv @@
module bmh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/binary_min_heap_priority_queue_unit.sv @@
// Binary min-heap of (signed priority, payload) entries held in one
// single-port-write, registered-read RAM. One item is worked on at a time:
// insert climbs from the new last slot (decrease key first reads the payload),
// extract reads the root and, if entries remain, sinks the last one from the
// root, and delete key runs both walks in turn, with one RAM read per parent
// or child visited. Full, empty and bad-index items go straight to the result.
// Ties never swap; a decrease key to a larger value only climbs. Occupancy
// saturates at 127.
module binary_min_heap_priority_queue_unit import bmh_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  bmh_in_if.sink    cmd,
  bmh_out_if.source res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [OCC_W-1:0] FULL_OCC = (CAPACITY > OCC_MAX) ? OCC_W'(OCC_MAX) :
                                                                 OCC_W'(CAPACITY);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RD   = 11'b00000000010,
    S_UR   = 11'b00000000100,
    S_UC   = 11'b00000001000,
    S_XR   = 11'b00000010000,
    S_XL   = 11'b00000100000,
    S_XM   = 11'b00001000000,
    S_DL   = 11'b00010000000,
    S_DR   = 11'b00100000000,
    S_DC   = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  state_t          state, state_next;
  mode_t           op, op_next;
  logic [AW-1:0]   idx, idx_next;
  logic [CW-1:0]   cnt, cnt_next;
  entry_t          cur, cur_next;
  entry_t          left, left_next;
  logic            has_r, has_r_next;
  status_t         rstat, rstat_next;
  entry_t          rent, rent_next;
  logic            out_valid;
  status_t         out_status;
  entry_t          out_entry;
  logic [OCC_W-1:0] out_occ;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wdata, rdata;
  logic            load_out;

  logic [LW-1:0]   lc, rc, cnt_l;
  logic [AW-1:0]   parent;
  logic [CMP_W-1:0] pos_w, cnt_w;
  logic            take_l, take_r;
  logic signed [PRIO_W-1:0] best_prio;

  bmh_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign lc     = {1'b0, idx, 1'b1};
  assign rc     = lc + LW'(1);
  assign cnt_l  = LW'(cnt);
  assign parent = (idx - AW'(1)) >> 1;
  assign pos_w  = CMP_W'(cmd.position);
  assign cnt_w  = CMP_W'(cnt);

  assign take_l    = $signed(left.prio) < $signed(cur.prio);
  assign best_prio = take_l ? left.prio : cur.prio;
  assign take_r    = has_r && ($signed(rdata.prio) < $signed(best_prio));

  assign cmd.ready = (state == S_IDLE);
  assign load_out  = (state == S_DONE) && (!out_valid || res.ready);

  always_comb begin
    state_next = state;
    op_next    = op;
    idx_next   = idx;
    cnt_next   = cnt;
    cur_next   = cur;
    left_next  = left;
    has_r_next = has_r;
    rstat_next = rstat;
    rent_next  = rent;
    we         = 1'b0;
    waddr      = idx;
    wdata      = cur;
    raddr      = '0;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          op_next    = mode_t'(cmd.mode);
          rstat_next = ST_OK;
          rent_next  = '0;
          case (mode_t'(cmd.mode))
            MODE_INSERT: begin
              if (cnt == CAP_CNT) begin
                rstat_next = ST_FULL;
                state_next = S_DONE;
              end else begin
                cur_next   = '{prio: cmd.priority_req, data: cmd.payload};
                idx_next   = cnt[AW-1:0];
                cnt_next   = cnt + CW'(1);
                state_next = S_UR;
              end
            end
            MODE_EXTRACT: begin
              if (cnt == '0) begin
                rstat_next = ST_EMPTY;
                state_next = S_DONE;
              end else begin
                state_next = S_XR;
              end
            end
            default: begin
              if (pos_w >= cnt_w) begin
                rstat_next = ST_RANGE;
                state_next = S_DONE;
              end else begin
                raddr         = pos_w[AW-1:0];
                idx_next      = pos_w[AW-1:0];
                cur_next.prio = (mode_t'(cmd.mode) == MODE_DECREASE) ?
                                cmd.priority_req : INT_MIN;
                state_next    = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        cur_next.data = rdata.data;
        state_next    = S_UR;
      end
      S_UR: begin
        if (idx == '0) begin
          we         = 1'b1;
          state_next = (op == MODE_DELETE) ? S_XR : S_DONE;
        end else begin
          raddr      = parent;
          state_next = S_UC;
        end
      end
      S_UC: begin
        we = 1'b1;
        if ($signed(rdata.prio) > $signed(cur.prio)) begin
          wdata      = rdata;
          idx_next   = parent;
          state_next = S_UR;
        end else begin
          state_next = (op == MODE_DELETE) ? S_XR : S_DONE;
        end
      end
      S_XR: begin
        raddr      = '0;
        state_next = S_XL;
      end
      S_XL: begin
        rent_next = rdata;
        cnt_next  = cnt - CW'(1);
        if (cnt_next != '0) begin
          raddr      = cnt_next[AW-1:0];
          state_next = S_XM;
        end else begin
          state_next = S_DONE;
        end
      end
      S_XM: begin
        cur_next   = rdata;
        idx_next   = '0;
        state_next = S_DL;
      end
      S_DL: begin
        if (lc >= cnt_l) begin
          we         = 1'b1;
          state_next = S_DONE;
        end else begin
          raddr      = lc[AW-1:0];
          state_next = S_DR;
        end
      end
      S_DR: begin
        left_next  = rdata;
        has_r_next = rc < cnt_l;
        raddr      = rc[AW-1:0];
        state_next = S_DC;
      end
      S_DC: begin
        we = 1'b1;
        if (take_r) begin
          wdata      = rdata;
          idx_next   = rc[AW-1:0];
          state_next = S_DL;
        end else if (take_l) begin
          wdata      = left;
          idx_next   = lc[AW-1:0];
          state_next = S_DL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    idx   <= idx_next;
    cur   <= cur_next;
    left  <= left_next;
    has_r <= has_r_next;
    rstat <= rstat_next;
    rent  <= rent_next;
    if (load_out) begin
      out_status <= rstat;
      out_entry  <= rent;
      out_occ    <= (cnt_w > CMP_W'(OCC_MAX)) ? OCC_W'(OCC_MAX) : cnt_w[OCC_W-1:0];
    end
  end

  assign res.valid        = out_valid;
  assign res.status       = out_status;
  assign res.out_priority = out_entry.prio;
  assign res.out_payload  = out_entry.data;
  assign res.occupancy    = out_occ;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_CNT) else $error("entry count above capacity");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_FULL) |-> out_occ == FULL_OCC)
    else $error("full reported below capacity");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_EMPTY) |-> out_occ == '0)
    else $error("empty reported with entries");
`endif

endmodule

@@ bench/tb_binary_min_heap_priority_queue_unit.sv @@
module tb_binary_min_heap_priority_queue_unit;
  import bmh_pkg::*;

  typedef struct packed {
    mode_t                    mode;
    logic signed [PRIO_W-1:0] prio;
    logic [DATA_W-1:0]        data;
    logic [POS_W-1:0]         pos;
  } op_t;

  typedef struct packed {
    status_t                  status;
    logic signed [PRIO_W-1:0] prio;
    logic [DATA_W-1:0]        data;
    logic [OCC_W-1:0]         occ;
  } outcome_t;

  localparam int CAP = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bmh_in_if  cmd ();
  bmh_out_if res ();

  binary_min_heap_priority_queue_unit #(.CAPACITY(CAP)) uut (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .res(res.source)
  );

  op_t      pending_ops[$];
  outcome_t awaited[$];

  // shadow heap
  entry_t heap[CAP];
  int     heap_n;

  int unsigned src_idle_pct = 37;
  int unsigned snk_idle_pct = 63;
  int unsigned hold_off = 0;
  bit          src_pause = 1'b0;
  int          errors = 0;
  int          accepted = 0;
  int          checked = 0;
  int          cycles = 0;
  int          n_full = 0, n_empty = 0, n_range = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void hswap(int a, int b);
    entry_t t;
    t = heap[a];
    heap[a] = heap[b];
    heap[b] = t;
  endfunction

  function automatic void climb(int i);
    int p;
    while (i != 0) begin
      p = (i - 1) / 2;
      if (heap[p].prio > heap[i].prio) begin
        hswap(i, p);
        i = p;
      end else break;
    end
  endfunction

  function automatic void settle(int i);
    int l, r, b;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      b = i;
      if (l < heap_n && heap[l].prio < heap[i].prio) b = l;
      if (r < heap_n && heap[r].prio < heap[b].prio) b = r;
      if (b == i) break;
      hswap(i, b);
      i = b;
    end
  endfunction

  function automatic entry_t pop_root();
    entry_t top;
    top = heap[0];
    heap_n--;
    if (heap_n > 0) begin
      heap[0] = heap[heap_n];
      settle(0);
    end
    return top;
  endfunction

  function automatic outcome_t apply_op(op_t op);
    outcome_t o;
    entry_t   e;
    o = '0;
    o.status = ST_OK;
    case (op.mode)
      MODE_INSERT: begin
        if (heap_n >= CAP) o.status = ST_FULL;
        else begin
          heap[heap_n].prio = op.prio;
          heap[heap_n].data = op.data;
          heap_n++;
          climb(heap_n - 1);
        end
      end
      MODE_EXTRACT: begin
        if (heap_n == 0) o.status = ST_EMPTY;
        else begin
          e = pop_root();
          o.prio = e.prio;
          o.data = e.data;
        end
      end
      default: begin
        if (op.pos >= heap_n) o.status = ST_RANGE;
        else if (op.mode == MODE_DECREASE) begin
          heap[op.pos].prio = op.prio;
          climb(op.pos);
        end else begin
          heap[op.pos].prio = INT_MIN;
          climb(op.pos);
          e = pop_root();
          o.prio = e.prio;
          o.data = e.data;
        end
      end
    endcase
    o.occ = (heap_n > OCC_MAX) ? OCC_W'(OCC_MAX) : OCC_W'(heap_n);
    return o;
  endfunction

  function automatic op_t mk(mode_t m, logic [31:0] p, logic [31:0] d, logic [5:0] q);
    op_t op;
    op.mode = m;
    op.prio = p;
    op.data = d;
    op.pos = q;
    return op;
  endfunction

  function automatic logic [31:0] rand_prio();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // random item with its insert share set by fill_bias so the heap wanders over its range
  function automatic op_t rand_op(int fill_bias);
    int k;
    k = $urandom_range(0, 99);
    if (k < fill_bias)
      return mk(MODE_INSERT, rand_prio(), $urandom, $urandom);
    else if (k < fill_bias + 20)
      return mk(MODE_EXTRACT, $urandom, $urandom, $urandom);
    else if (k < fill_bias + 30)
      return mk(MODE_DECREASE, rand_prio(), $urandom, $urandom_range(0, 63));
    else
      return mk(MODE_DELETE, $urandom, $urandom, $urandom_range(0, 63));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        void'(pending_ops.pop_front());
        awaited.push_back(apply_op({cmd.mode, cmd.priority_req, cmd.payload, cmd.position}));
        accepted++;
      end
      if (!(cmd.valid && !cmd.ready)) begin
        if (pending_ops.size() > ((cmd.valid && cmd.ready) ? 0 : 0) && !src_pause &&
            $urandom_range(0, 99) >= src_idle_pct) begin
          cmd.valid        <= 1'b1;
          cmd.mode         <= pending_ops[0].mode;
          cmd.priority_req <= pending_ops[0].prio;
          cmd.payload      <= pending_ops[0].data;
          cmd.position     <= pending_ops[0].pos;
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // sink ready and result check
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      cycles++;
      if (res.valid && res.ready) begin
        checked++;
        if (awaited.size() == 0) begin
          $display("%0t: unexpected item st=%0d prio=%0d data=%h occ=%0d", $time,
                   res.status, res.out_priority, res.out_payload, res.occupancy);
          errors++;
        end else begin
          want = awaited.pop_front();
          if (res.status !== want.status || res.out_priority !== want.prio ||
              res.out_payload !== want.data || res.occupancy !== want.occ) begin
            $display("%0t: mismatch expected st=%0d prio=%0d data=%h occ=%0d", $time,
                     want.status, want.prio, want.data, want.occ);
            $display("%0t:          actual   st=%0d prio=%0d data=%h occ=%0d", $time,
                     res.status, res.out_priority, res.out_payload, res.occupancy);
            errors++;
          end
          case (want.status)
            ST_FULL:  n_full++;
            ST_EMPTY: n_empty++;
            ST_RANGE: n_range++;
            default: ;
          endcase
        end
      end
      if (hold_off != 0) begin
        hold_off <= hold_off - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb_binary_min_heap_priority_queue_unit: errors");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_ops.size() != 0 || cmd.valid || awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    cmd.valid = 1'b0;
    cmd.mode = MODE_INSERT;
    cmd.priority_req = '0;
    cmd.payload = '0;
    cmd.position = '0;
    res.ready = 1'b0;
    heap_n = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, extremes, ties, broken order, bad index
    pending_ops.push_back(mk(MODE_EXTRACT, 0, 0, 0));
    pending_ops.push_back(mk(MODE_DECREASE, 5, 0, 0));
    pending_ops.push_back(mk(MODE_DELETE, 0, 0, 0));
    pending_ops.push_back(mk(MODE_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 6'h3f));
    pending_ops.push_back(mk(MODE_INSERT, 32'h8000_0000, 32'h0000_0000, 0));
    pending_ops.push_back(mk(MODE_INSERT, 32'h0000_0000, 32'haaaa_5555, 0));
    pending_ops.push_back(mk(MODE_INSERT, 32'hffff_ffff, 32'h5555_aaaa, 0));
    pending_ops.push_back(mk(MODE_INSERT, 32'h0000_0001, 32'h1234_5678, 0));
    pending_ops.push_back(mk(MODE_DECREASE, 32'h7fff_ffff, 0, 1));  // larger value
    pending_ops.push_back(mk(MODE_DECREASE, 32'h8000_0000, 0, 4));  // ties root
    pending_ops.push_back(mk(MODE_DELETE, 0, 0, 2));                 // INT_MIN already present
    pending_ops.push_back(mk(MODE_DECREASE, 0, 0, 6'h3f));
    pending_ops.push_back(mk(MODE_DELETE, 0, 0, 4));
    pending_ops.push_back(mk(MODE_EXTRACT, 0, 0, 0));
    pending_ops.push_back(mk(MODE_EXTRACT, 0, 0, 0));
    pending_ops.push_back(mk(MODE_EXTRACT, 0, 0, 0));
    pending_ops.push_back(mk(MODE_EXTRACT, 0, 0, 0));
    pending_ops.push_back(mk(MODE_EXTRACT, 0, 0, 0));
    // fill past capacity while the receiver holds off
    for (i = 0; i < CAP + 3; i++)
      pending_ops.push_back(mk(MODE_INSERT, rand_prio(), $urandom, $urandom));
    hold_off = 300;
    drain();
    src_pause = 1'b1;
    repeat (20) @(posedge clk);
    src_pause = 1'b0;
    for (i = 0; i < 20; i++) pending_ops.push_back(mk(MODE_DELETE, 0, 0, $urandom_range(0, 63)));
    for (i = 0; i < CAP + 2; i++) pending_ops.push_back(mk(MODE_EXTRACT, 0, 0, 0));
    drain();

    for (i = 0; i < 280; i++) pending_ops.push_back(rand_op(i % 140 < 70 ? 60 : 25));
    drain();
    src_idle_pct = 63;
    snk_idle_pct = 37;
    for (i = 0; i < 280; i++) pending_ops.push_back(rand_op(i % 140 < 70 ? 65 : 20));
    drain();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (i = 0; i < 200; i++) pending_ops.push_back(rand_op(i % 100 < 50 ? 55 : 30));
    drain();
    repeat (60) @(posedge clk);

    $display("%0d items sent, %0d results checked", accepted, checked);
    $display("status hits: full %0d, empty %0d, bad index %0d", n_full, n_empty, n_range);
    if (errors == 0 && awaited.size() == 0)
      $display("tb_binary_min_heap_priority_queue_unit: clean");
    else
      $display("tb_binary_min_heap_priority_queue_unit: errors");
    $finish;
  end

endmodule
